[sv/positional_list_engine_defines.svh]
// Assertion macros used by the checker file of the positional list engine.
// Each macro expects clk and rst_n to be visible in the scope where it is used.
`ifndef POSITIONAL_LIST_ENGINE_DEFINES_SVH
`define POSITIONAL_LIST_ENGINE_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define PLE_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define PLE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[sv/ple_pkg.sv]
package ple_pkg;

    localparam int ELEM_W = 32;
    localparam int LEN_W  = 5;
    localparam int POS_W  = 8;

    typedef enum logic [2:0] {
        KIND_ADD_FIRST,
        KIND_ADD_LAST,
        KIND_ADD_POS,
        KIND_DEL_FIRST,
        KIND_DEL_LAST,
        KIND_DEL_POS,
        KIND_READ_FWD,
        KIND_READ_REV
    } kind_t;

    typedef enum logic [1:0] {
        STATUS_OK,
        STATUS_FULL,
        STATUS_EMPTY,
        STATUS_RANGE
    } status_t;

    typedef struct packed {
        kind_t                    kind;
        logic signed [ELEM_W-1:0] value;
        logic [POS_W-1:0]         position;
    } cmd_t;

    typedef struct packed {
        status_t                  status;
        logic signed [ELEM_W-1:0] element;
        logic [LEN_W-1:0]         length;
        logic                     last;
    } rsp_t;

    // Operation broadcast to every cell of the chain.
    typedef enum logic [2:0] {
        CM_HOLD,
        CM_INSERT,
        CM_DELETE,
        CM_ROT_FWD,
        CM_ROT_REV
    } cell_mode_t;

    typedef struct packed {
        cell_mode_t        mode;
        logic [ELEM_W-1:0] value;
    } cell_ctl_t;

    typedef enum logic {
        ST_IDLE,
        ST_READ
    } state_t;

endpackage

[sv/ple_cell.sv]
module ple_cell #(
    parameter int INDEX = 0,
    parameter int IDX_W = 4
) (
    input  logic                       clk,
    input  ple_pkg::cell_ctl_t         ctl,
    input  logic [IDX_W-1:0]           sel_idx,
    input  logic [IDX_W-1:0]           tail_idx,
    input  logic [ple_pkg::ELEM_W-1:0] left_elem,
    input  logic [ple_pkg::ELEM_W-1:0] right_elem,
    input  logic [ple_pkg::ELEM_W-1:0] head_elem,
    input  logic [ple_pkg::ELEM_W-1:0] tail_elem,
    output logic [ple_pkg::ELEM_W-1:0] elem
);

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);

    logic [ple_pkg::ELEM_W-1:0] elem_reg;
    logic [ple_pkg::ELEM_W-1:0] elem_next;

    // Each cell decides from its own position which neighbor it takes.
    always_comb
    begin
        elem_next = elem_reg;
        case (ctl.mode)
            ple_pkg::CM_HOLD:
            begin
                elem_next = elem_reg;
            end
            ple_pkg::CM_INSERT:
            begin
                if (MY_IDX > sel_idx)
                begin
                    elem_next = left_elem;
                end
                else if (MY_IDX == sel_idx)
                begin
                    elem_next = ctl.value;
                end
            end
            ple_pkg::CM_DELETE:
            begin
                if (MY_IDX >= sel_idx)
                begin
                    elem_next = right_elem;
                end
            end
            ple_pkg::CM_ROT_FWD:
            begin
                if (MY_IDX == tail_idx)
                begin
                    elem_next = head_elem;
                end
                else if (MY_IDX < tail_idx)
                begin
                    elem_next = right_elem;
                end
            end
            ple_pkg::CM_ROT_REV:
            begin
                if (INDEX == 0)
                begin
                    elem_next = tail_elem;
                end
                else if (MY_IDX <= tail_idx)
                begin
                    elem_next = left_elem;
                end
            end
            default:
            begin
                elem_next = elem_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        elem_reg <= elem_next;
    end

    assign elem = elem_reg;

endmodule

[sv/positional_list_engine.sv]
// Positional list engine: an ordered list of up to DEPTH signed 32-bit values.
// The cmd channel takes one word per operation (kind, value, position); the rsp
// channel returns status, element, list length after the operation and a last
// flag that marks the final rsp word of each cmd word. Both use valid/ready.
// Inserts and deletes act at once on the chain: every cell from the chosen
// slot onward takes its new value at the same clock edge, so one rsp word
// is produced in the accept cycle. A forward or reverse read rotates the
// chain one step per cycle inside the occupied cells while the rsp queue
// has room, sends out the head (or tail) each step, and so gives N words
// for N elements and leaves the list in its original order; a read of an
// empty list gives one word. A new cmd word is taken only when no read is
// in progress and the rsp queue has room. The rsp side has a two-word
// queue: a cmd word can be taken while a finished rsp word waits, and a
// stalled receiver simply holds the read rotation and blocks cmd until the
// queue has room. The rsp word of an insert, delete or failure enters the
// queue in the accept cycle; the first word of a non-empty read enters it
// once the sequencer is in its read state. Reset clears the length, the
// queue and the sequencer; cell contents are left as they are and are
// never shown before being written.
module positional_list_engine #(
    parameter int DEPTH = 16
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cmd_valid,
    output logic          cmd_ready,
    input  ple_pkg::cmd_t cmd,
    output logic          rsp_valid,
    input  logic          rsp_ready,
    output ple_pkg::rsp_t rsp
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam int IW = $clog2(DEPTH);

    // Control state.
    ple_pkg::state_t state_reg;
    ple_pkg::state_t state_next;
    logic [CW-1:0]   count_reg;
    logic [CW-1:0]   count_next;
    logic [CW-1:0]   rd_left_reg;
    logic [CW-1:0]   rd_left_next;
    logic            rev_reg;
    logic            rev_next;

    // Two-word rsp queue; slot 0 drives the ports.
    ple_pkg::rsp_t q0_reg;
    ple_pkg::rsp_t q0_next;
    ple_pkg::rsp_t q1_reg;
    ple_pkg::rsp_t q1_next;
    logic [1:0]    qn_reg;
    logic [1:0]    qn_next;
    logic [1:0]    q_level;
    logic          pop;
    logic          space;
    logic          push;
    ple_pkg::rsp_t push_word;

    // Chain of cells.
    logic [DEPTH-1:0][ple_pkg::ELEM_W-1:0] elems;
    ple_pkg::cell_ctl_t                    ctl;
    logic [IW-1:0]                         sel_idx;
    logic [IW-1:0]                         tail_idx;
    logic [ple_pkg::ELEM_W-1:0]            head_elem;
    logic [ple_pkg::ELEM_W-1:0]            tail_elem;

    logic       accept;
    logic       is_full;
    logic       is_empty;
    logic [8:0] pos9;
    logic [8:0] cnt9;
    logic [IW-1:0] pos_idx;

    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++)
        begin : g_cell
            logic [ple_pkg::ELEM_W-1:0] left_w;
            logic [ple_pkg::ELEM_W-1:0] right_w;
            if (gi == 0)
            begin : g_first
                assign left_w = elems[gi];
            end
            else
            begin : g_inner_l
                assign left_w = elems[gi-1];
            end
            if (gi == DEPTH - 1)
            begin : g_last
                assign right_w = elems[gi];
            end
            else
            begin : g_inner_r
                assign right_w = elems[gi+1];
            end
            ple_cell #(
                .INDEX (gi),
                .IDX_W (IW)
            ) u_cell (
                .clk        (clk),
                .ctl        (ctl),
                .sel_idx    (sel_idx),
                .tail_idx   (tail_idx),
                .left_elem  (left_w),
                .right_elem (right_w),
                .head_elem  (head_elem),
                .tail_elem  (tail_elem),
                .elem       (elems[gi])
            );
        end
    endgenerate

    assign head_elem = elems[0];
    assign tail_idx  = IW'(count_reg - CW'(1));
    assign tail_elem = elems[tail_idx];

    assign pop       = (qn_reg != 2'd0) && rsp_ready;
    assign space     = (qn_reg != 2'd2) || pop;
    assign cmd_ready = (state_reg == ple_pkg::ST_IDLE) && space;
    assign accept    = cmd_valid && cmd_ready;

    assign is_full  = (count_reg == CW'(DEPTH));
    assign is_empty = (count_reg == '0);
    assign pos9     = {1'b0, cmd.position};
    assign cnt9     = 9'(count_reg);
    assign pos_idx  = IW'(cmd.position - 8'd1);

    // Next state of the read sequencer.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ple_pkg::ST_IDLE:
            begin
                if (accept && !is_empty &&
                    (cmd.kind == ple_pkg::KIND_READ_FWD ||
                     cmd.kind == ple_pkg::KIND_READ_REV))
                begin
                    state_next = ple_pkg::ST_READ;
                end
            end
            ple_pkg::ST_READ:
            begin
                if (space && rd_left_reg == CW'(1))
                begin
                    state_next = ple_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = ple_pkg::ST_IDLE;
            end
        endcase
    end

    // Cell commands, list length and rsp words.
    always_comb
    begin
        ctl.mode          = ple_pkg::CM_HOLD;
        ctl.value         = cmd.value;
        sel_idx           = '0;
        count_next        = count_reg;
        rd_left_next      = rd_left_reg;
        rev_next          = rev_reg;
        push              = 1'b0;
        push_word.status  = ple_pkg::STATUS_OK;
        push_word.element = '0;
        push_word.last    = 1'b1;
        case (state_reg)
            ple_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    push = 1'b1;
                    case (cmd.kind)
                        ple_pkg::KIND_ADD_FIRST, ple_pkg::KIND_ADD_LAST,
                        ple_pkg::KIND_ADD_POS:
                        begin
                            if (is_full)
                            begin
                                push_word.status = ple_pkg::STATUS_FULL;
                            end
                            else if (cmd.kind == ple_pkg::KIND_ADD_POS &&
                                     pos9 > cnt9 + 9'd1)
                            begin
                                push_word.status = ple_pkg::STATUS_RANGE;
                            end
                            else
                            begin
                                ctl.mode   = ple_pkg::CM_INSERT;
                                count_next = count_reg + CW'(1);
                                if (cmd.kind == ple_pkg::KIND_ADD_LAST)
                                begin
                                    sel_idx = IW'(count_reg);
                                end
                                else if (cmd.kind == ple_pkg::KIND_ADD_POS &&
                                         cmd.position > 8'd1)
                                begin
                                    sel_idx = pos_idx;
                                end
                            end
                        end
                        ple_pkg::KIND_DEL_FIRST, ple_pkg::KIND_DEL_LAST,
                        ple_pkg::KIND_DEL_POS:
                        begin
                            if (is_empty)
                            begin
                                push_word.status = ple_pkg::STATUS_EMPTY;
                            end
                            else if (cmd.kind == ple_pkg::KIND_DEL_POS && pos9 > cnt9)
                            begin
                                push_word.status = ple_pkg::STATUS_RANGE;
                            end
                            else
                            begin
                                ctl.mode   = ple_pkg::CM_DELETE;
                                count_next = count_reg - CW'(1);
                                if (cmd.kind == ple_pkg::KIND_DEL_LAST)
                                begin
                                    sel_idx = tail_idx;
                                end
                                else if (cmd.kind == ple_pkg::KIND_DEL_POS &&
                                         cmd.position > 8'd1)
                                begin
                                    sel_idx = pos_idx;
                                end
                            end
                        end
                        default:
                        begin
                            // Reads: an empty list answers at once, otherwise
                            // the sequencer streams the elements out.
                            if (is_empty)
                            begin
                                push_word.status = ple_pkg::STATUS_EMPTY;
                            end
                            else
                            begin
                                push         = 1'b0;
                                rd_left_next = count_reg;
                                rev_next     = (cmd.kind == ple_pkg::KIND_READ_REV);
                            end
                        end
                    endcase
                end
            end
            ple_pkg::ST_READ:
            begin
                if (space)
                begin
                    push              = 1'b1;
                    push_word.element = rev_reg ? tail_elem : head_elem;
                    push_word.last    = (rd_left_reg == CW'(1));
                    ctl.mode          = rev_reg ? ple_pkg::CM_ROT_REV : ple_pkg::CM_ROT_FWD;
                    rd_left_next      = rd_left_reg - CW'(1);
                end
            end
            default:
            begin
                ctl.mode = ple_pkg::CM_HOLD;
            end
        endcase
        push_word.length = ple_pkg::LEN_W'(count_next);
    end

    // Rsp queue bookkeeping.
    assign q_level = qn_reg - {1'b0, pop};

    always_comb
    begin
        q0_next = q0_reg;
        q1_next = q1_reg;
        if (pop)
        begin
            q0_next = q1_reg;
        end
        if (push)
        begin
            if (q_level == 2'd0)
            begin
                q0_next = push_word;
            end
            else
            begin
                q1_next = push_word;
            end
        end
        qn_next = q_level + {1'b0, push};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ple_pkg::ST_IDLE;
            count_reg   <= '0;
            rd_left_reg <= '0;
            rev_reg     <= 1'b0;
            qn_reg      <= 2'd0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            rd_left_reg <= rd_left_next;
            rev_reg     <= rev_next;
            qn_reg      <= qn_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q0_reg <= q0_next;
        q1_reg <= q1_next;
    end

    assign rsp_valid = (qn_reg != 2'd0);
    assign rsp       = q0_reg;

endmodule

[sv/ple_checker.sv]
`include "positional_list_engine_defines.svh"

module ple_checker (
    input logic          clk,
    input logic          rst_n,
    input logic          cmd_valid,
    input logic          cmd_ready,
    input ple_pkg::cmd_t cmd,
    input logic          rsp_valid,
    input logic          rsp_ready,
    input ple_pkg::rsp_t rsp
);

    // A stalled rsp word stays offered.
    `PLE_ASSERT_NEXT(a_rsp_valid_holds, rsp_valid && !rsp_ready, rsp_valid, "rsp_valid dropped while stalled")

    // A stalled rsp word keeps its payload.
    `PLE_ASSERT_NEXT(a_rsp_stable, rsp_valid && !rsp_ready, $stable(rsp), "rsp changed while stalled")

    // Any word that reports a failure is the only word of its operation.
    `PLE_ASSERT_SAME(a_err_is_last, rsp_valid && rsp.status != ple_pkg::STATUS_OK, rsp.last, "error word without last")

    // Failure words carry no element.
    `PLE_ASSERT_SAME(a_err_no_elem, rsp_valid && rsp.status != ple_pkg::STATUS_OK, rsp.element == '0, "error word with nonzero element")

    // Once a read word without last is taken, the next word follows at once.
    `PLE_ASSERT_NEXT(a_read_stream, rsp_valid && rsp_ready && !rsp.last, rsp_valid, "gap inside a read stream")

endmodule

bind positional_list_engine ple_checker u_ple_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
);
